### rtl/sist_pkg.sv
// Shared types and constants for the sorted identifier set table.
// Used by sist_ctrl, sist_dp and sorted_id_set_table; depends on nothing else.
package sist_pkg;

    localparam int OP_W    = 2;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef logic [OP_W-1:0] t_opcode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the incoming item
        logic compare;  // register the per-entry compare flags
        logic update;   // apply the operation and load the result register
    } t_dp_cmd;

endpackage

### rtl/sist_ctrl.sv
// Controller for the sorted identifier set table: sequences compare and update.
// Depends on sist_pkg.
module sist_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_ready,
    output logic              o_ready,
    output logic              o_valid,
    output sist_pkg::t_dp_cmd o_cmd
);
    import sist_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   upd_go;
    logic   accept;

    // The update may proceed once the result register is free or being emptied.
    assign upd_go  = (r_state == ST_UPD) && (!r_out_valid || i_ready);
    assign o_ready = (r_state == ST_IDLE) || upd_go;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_valid;

    always_comb begin
        o_cmd.load    = accept;
        o_cmd.compare = (r_state == ST_CMP);
        o_cmd.update  = upd_go;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (upd_go) begin
                    n_out_valid = 1'b1;
                    n_state     = accept ? ST_CMP : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/sist_dp.sv
// Datapath for the sorted identifier set table: a row of key cells that compare
// in parallel and shift one place on insert or remove. Depends on sist_pkg.
module sist_dp #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sist_pkg::t_dp_cmd              i_cmd,
    input  sist_pkg::t_opcode              i_opcode,
    input  logic [KEY_BITS-1:0]            i_key,
    output logic                           o_was_present,
    output logic [sist_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                           o_full_reject
);
    import sist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [KEY_BITS-1:0] r_cells [CAPACITY];
    logic [KEY_BITS-1:0] n_cells [CAPACITY];
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    t_opcode             r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [CAPACITY-1:0] r_lt;
    logic [CAPACITY-1:0] r_eq;
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] eq;
    logic                present;
    logic                full;
    logic                do_ins;
    logic                do_rem;
    logic                reject;
    logic                r_present;
    logic                r_reject;
    logic [COUNT_W-1:0]  r_out_count;

    // Each cell only compares when it lies below the fill count.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
        logic valid;
        logic lt_prev;
        assign valid   = r_count > IDX;
        assign lt[g]   = valid && (r_cells[g] < r_key);
        assign eq[g]   = valid && (r_cells[g] == r_key);
        if (g == 0) begin : g_first
            assign lt_prev = 1'b1;
        end else begin : g_rest
            assign lt_prev = r_lt[g-1];
        end

        always_comb begin
            n_cells[g] = r_cells[g];
            if (do_ins && !r_lt[g]) begin
                if (lt_prev) begin
                    n_cells[g] = r_key;
                end else if (g > 0) begin
                    n_cells[g] = r_cells[(g > 0) ? g - 1 : 0];
                end
            end else if (do_rem && !r_lt[g] && (g < CAPACITY - 1)) begin
                n_cells[g] = r_cells[(g < CAPACITY - 1) ? g + 1 : g];
            end
        end
    end

    assign present = |r_eq;
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign do_ins  = (r_op == OP_INSERT) && !present && !full;
    assign reject  = (r_op == OP_INSERT) && !present && full;
    assign do_rem  = (r_op == OP_REMOVE) && present;

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_key <= i_key;
        end
        if (i_cmd.compare) begin
            r_lt <= lt;
            r_eq <= eq;
        end
        if (i_cmd.update) begin
            r_cells     <= n_cells;
            r_present   <= present;
            r_reject    <= reject;
            r_out_count <= COUNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.update) begin
            r_count <= n_count;
        end
    end

    assign o_was_present = r_present;
    assign o_entry_count = r_out_count;
    assign o_full_reject = r_reject;

endmodule

### rtl/sorted_id_set_table.sv
// Top level of the sorted identifier set table: controller plus cell datapath.
// Depends on sist_pkg, sist_ctrl and sist_dp.
//
//   Channel  Handshake          Payload
//   input    i_valid / o_ready  i_opcode, i_key
//   output   o_valid / i_ready  o_was_present, o_entry_count, o_full_reject
//
// Each item passes through a compare state, which checks the key against every
// cell at once, and an update state, which shifts the row and loads the result
// register. A new item can be taken in the update state of the one before it.
// The update waits while an earlier result is still held in the output register.
// In the datapath, reset clears only the fill count; cell contents are meaningless until written.
module sorted_id_set_table #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  sist_pkg::t_opcode            i_opcode,
    input  logic [KEY_BITS-1:0]          i_key,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_was_present,
    output logic [sist_pkg::COUNT_W-1:0] o_entry_count,
    output logic                         o_full_reject
);
    import sist_pkg::*;

    t_dp_cmd cmd;

    sist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    sist_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .o_was_present (o_was_present),
        .o_entry_count (o_entry_count),
        .o_full_reject (o_full_reject)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_id_set_table: directed and random insert, remove and query items.
// Holds its own model of the sorted set and compares each result field by field.
// Depends on sist_pkg and the sorted_id_set_table RTL.
module tb;
    import sist_pkg::*;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;
    localparam int POOL_SIZE = 24;
    // The fourth opcode has no operation of its own and behaves as a query.
    localparam t_opcode OP_UNUSED = 2'd3;

    typedef struct packed {
        logic               was_present;
        logic [COUNT_W-1:0] entry_count;
        logic               full_reject;
    } t_outcome;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_ready = 1'b0;
    t_opcode             i_opcode = OP_QUERY;
    logic [KEY_BITS-1:0] i_key = '0;
    logic                o_ready;
    logic                o_valid;
    logic                o_was_present;
    logic [COUNT_W-1:0]  o_entry_count;
    logic                o_full_reject;

    sorted_id_set_table #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_opcode(i_opcode),
        .i_key(i_key),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_was_present(o_was_present),
        .o_entry_count(o_entry_count),
        .o_full_reject(o_full_reject)
    );

    always #5 i_clk = ~i_clk;

    // Our own copy of the set, kept in ascending order.
    logic [KEY_BITS-1:0] held_keys [CAPACITY];
    int                  held_count = 0;
    t_outcome            pending_outcomes [$];
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    int                  n_errors = 0;
    bit                  quiet_tx = 1'b0;
    bit                  quiet_rx = 1'b0;
    int                  rx_hold = 0;

    function automatic t_outcome apply_set_op(t_opcode op, logic [KEY_BITS-1:0] key);
        t_outcome res;
        bit       found;
        int       pos;
        int       at;
        found = 1'b0;
        pos = 0;
        for (int i = 0; i < held_count; i++) begin
            if (!found && held_keys[i] == key) begin
                found = 1'b1;
                pos = i;
            end
        end
        res.full_reject = 1'b0;
        if (op == OP_INSERT && !found) begin
            if (held_count >= CAPACITY) begin
                res.full_reject = 1'b1;
            end else begin
                at = 0;
                while (at < held_count && held_keys[at] < key)
                    at++;
                for (int i = held_count; i > at; i--)
                    held_keys[i] = held_keys[i-1];
                held_keys[at] = key;
                held_count++;
            end
        end else if (op == OP_REMOVE && found) begin
            for (int i = pos; i + 1 < held_count; i++)
                held_keys[i] = held_keys[i+1];
            held_count--;
        end
        res.was_present = found;
        res.entry_count = held_count[COUNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(t_opcode op, logic [KEY_BITS-1:0] key);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_key    <= key;
        do @(posedge i_clk); while (!o_ready);
        pending_outcomes.push_back(apply_set_op(op, key));
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, count %0d",
                                          o_entry_count));
            end else begin
                want = pending_outcomes.pop_front();
                check_field("was_present", o_was_present, want.was_present);
                check_field("entry_count", o_entry_count, want.entry_count);
                check_field("full_reject", o_full_reject, want.full_reject);
            end
        end
    end

    // Result side: a random hold-off before each result, or a long one on request.
    initial begin : result_sink
        int stall;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end else begin
                stall = quiet_rx ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    task automatic test_basic_ops();
        send_item(OP_QUERY, '0);
        send_item(OP_REMOVE, 32'h0000_0005);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, '1);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_QUERY, '1);
        send_item(OP_UNUSED, '0);
        send_item(OP_UNUSED, 32'h1234_5678);
        send_item(OP_REMOVE, 32'h8000_0000);
        send_item(OP_REMOVE, 32'h8000_0000);
        send_item(OP_QUERY, 32'h5555_5555);
    endtask

    task automatic test_capacity();
        for (int i = 0; i < CAPACITY - 2; i++)
            send_item(OP_INSERT, i * 32'h1111_1111 + 1);
        // Table is full now: a new key is refused, a known key is a plain duplicate.
        send_item(OP_INSERT, 32'h7777_7777);
        send_item(OP_INSERT, '0);
        send_item(OP_REMOVE, '1);
        send_item(OP_REMOVE, '0);
    endtask

    task automatic run_random_ops(int n_items, int insert_pct, int remove_pct);
        int                  r;
        t_opcode             op;
        logic [KEY_BITS-1:0] key;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(0, 99);
            if (r < insert_pct)
                op = OP_INSERT;
            else if (r < insert_pct + remove_pct)
                op = OP_REMOVE;
            else if (r < 97)
                op = OP_QUERY;
            else
                op = OP_UNUSED;
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : $urandom();
            send_item(op, key);
        end
    endtask

    task automatic test_random_set_ops();
        // A small pool, larger than the table, so that keys collide and the table fills.
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = (i < held_count) ? held_keys[i] : $urandom();
        key_pool[POOL_SIZE-1] = '1;
        key_pool[POOL_SIZE-2] = '0;
        run_random_ops(300, 60, 20);
        quiet_rx = 1'b1;
        run_random_ops(300, 20, 60);
        quiet_rx = 1'b0;
        quiet_tx = 1'b1;
        run_random_ops(300, 40, 40);
        quiet_tx = 1'b0;
    endtask

    task automatic test_back_to_back();
        quiet_tx = 1'b1;
        quiet_rx = 1'b1;
        run_random_ops(150, 45, 35);
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    task automatic test_output_stall();
        // The sink holds off for a long stretch while items keep coming.
        rx_hold = 80;
        quiet_tx = 1'b1;
        run_random_ops(20, 45, 35);
        quiet_tx = 1'b0;
        run_random_ops(150, 45, 35);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_basic_ops();
        test_capacity();
        test_random_set_ops();
        test_back_to_back();
        test_output_stall();
        i_valid <= 1'b0;
        wait (pending_outcomes.size() == 0);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

### files.f
rtl/sist_pkg.sv
rtl/sist_ctrl.sv
rtl/sist_dp.sv
rtl/sorted_id_set_table.sv
bench/tb.sv
